### rtl/i2cram_pkg.sv
package i2cram_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned PHASE_W     = 4;
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [PHASE_W-1:0] PH_IDLE     = 4'd0;
    localparam logic [PHASE_W-1:0] PH_START1   = 4'd1;
    localparam logic [PHASE_W-1:0] PH_START2   = 4'd2;
    localparam logic [PHASE_W-1:0] PH_BIT_HIGH = 4'd3;
    localparam logic [PHASE_W-1:0] PH_BIT_LOW  = 4'd4;
    localparam logic [PHASE_W-1:0] PH_ACK_WAIT = 4'd5;
    localparam logic [PHASE_W-1:0] PH_ACK_POLL = 4'd6;
    localparam logic [PHASE_W-1:0] PH_ACK_HIGH = 4'd7;
    localparam logic [PHASE_W-1:0] PH_ACK_LOW  = 4'd8;
    localparam logic [PHASE_W-1:0] PH_RD_HIGH  = 4'd9;
    localparam logic [PHASE_W-1:0] PH_RD_LOW   = 4'd10;
    localparam logic [PHASE_W-1:0] PH_STOP1    = 4'd11;
    localparam logic [PHASE_W-1:0] PH_STOP2    = 4'd12;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SCL_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCL_HIGH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_SETUP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BUS_FREE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_DELAY = 3'd5;

    localparam logic [BYTE_W-1:0] RST_SCL_LOW     = 8'd2;
    localparam logic [BYTE_W-1:0] RST_SCL_HIGH    = 8'd1;
    localparam logic [BYTE_W-1:0] RST_STOP_SETUP  = 8'd1;
    localparam logic [BYTE_W-1:0] RST_BUS_FREE    = 8'd2;
    localparam logic [BYTE_W-1:0] RST_RETRY_LIMIT = 8'd10;
    localparam logic [BYTE_W-1:0] RST_RETRY_DELAY = 8'd1;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam logic [1:0] READ_DATA_IDX = 2'd2;
    localparam logic [1:0] LAST_BYTE_IDX = 2'd3;

    typedef struct packed {
        logic              start;
        logic              rd;
        logic [BYTE_W-1:0] dev_addr;
        logic [BYTE_W-1:0] reg_addr;
        logic [BYTE_W-1:0] write_data;
        logic              sda_in;
    } t_item;

    function automatic logic [BYTE_W-1:0] at_least_one(input logic [BYTE_W-1:0] v);
        at_least_one = (v == '0) ? 8'd1 : v;
    endfunction

endpackage

### rtl/i2cram_front.sv
module i2cram_front #(
    parameter int unsigned QueueDepth = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [1:0]                 i_command,
    input  logic [7:0]                 i_dev_addr,
    input  logic [7:0]                 i_reg_addr,
    input  logic [7:0]                 i_write_data,
    input  logic                       i_sda_in,
    output logic                       o_q_valid,
    output i2cram_pkg::t_item          o_q_item,
    input  logic                       i_q_pop
);
    import i2cram_pkg::*;

    localparam int unsigned PtrW = $clog2(QueueDepth);
    localparam int unsigned CntW = $clog2(QueueDepth + 1);

    t_item            r_mem [QueueDepth];
    logic [PtrW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0]  r_count, n_count;
    t_item            w_item;
    logic             w_push;

    // classify the command: unknown codes are plain ticks
    always_comb begin
        w_item.start      = (i_command == CMD_WRITE) || (i_command == CMD_READ);
        w_item.rd         = (i_command == CMD_READ);
        w_item.dev_addr   = i_dev_addr;
        w_item.reg_addr   = i_reg_addr;
        w_item.write_data = i_write_data;
        w_item.sda_in     = i_sda_in;
    end

    assign o_stall   = (r_count == CntW'(QueueDepth));
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_count != '0);
    assign o_q_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_q_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !i_q_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_push && i_q_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

endmodule

### rtl/i2cram_engine.sv
module i2cram_engine (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [i2cram_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [7:0]                           i_cfg_wdata,
    input  logic                                 i_q_valid,
    input  i2cram_pkg::t_item                    i_q_item,
    output logic                                 o_q_pop,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic                                 o_scl_level,
    output logic                                 o_sda_drive,
    output logic                                 o_sda_level,
    output logic                                 o_busy_res,
    output logic                                 o_done_res,
    output logic                                 o_success,
    output logic [7:0]                           o_read_data
);
    import i2cram_pkg::*;

    logic [BYTE_W-1:0]  r_scl_low, r_scl_high, r_stop_setup;
    logic [BYTE_W-1:0]  r_bus_free, r_retry_limit, r_retry_delay;

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [1:0]         r_byte_index, n_byte_index;
    logic [3:0]         r_bit_count, n_bit_count;
    logic [BYTE_W-1:0]  r_tick_count, n_tick_count;
    logic [BYTE_W-1:0]  r_retry_count, n_retry_count;
    logic [BYTE_W-1:0]  r_shift, n_shift;
    logic               r_is_read, n_is_read;
    logic [BYTE_W-1:0]  r_held [3];
    logic               r_scl, n_scl;
    logic               r_sda_drive, n_sda_drive;
    logic               r_sda_level, n_sda_level;
    logic [BYTE_W-1:0]  r_read, n_read;
    logic               r_done, n_done;
    logic               r_success, n_success;
    logic               r_out_valid;
    logic [BYTE_W-1:0]  w_held_sel;
    logic [BYTE_W-1:0]  w_scl_low_eff;

    assign o_q_pop = i_q_valid && (!r_out_valid || !i_stall);

    assign w_scl_low_eff = at_least_one(r_scl_low);

    always_comb begin
        case (n_byte_index)
            2'd0:    w_held_sel = r_held[0];
            2'd1:    w_held_sel = r_held[1];
            2'd2:    w_held_sel = r_held[2];
            default: w_held_sel = '0;
        endcase
    end

    // one tick of the bus sequencer
    always_comb begin
        n_phase       = r_phase;
        n_byte_index  = r_byte_index;
        n_bit_count   = r_bit_count;
        n_tick_count  = r_tick_count;
        n_retry_count = r_retry_count;
        n_shift       = r_shift;
        n_is_read     = r_is_read;
        n_scl         = r_scl;
        n_sda_drive   = r_sda_drive;
        n_sda_level   = r_sda_level;
        n_read        = r_read;
        n_done        = 1'b0;
        n_success     = 1'b0;

        if (r_phase == PH_IDLE) begin
            if (i_q_item.start) begin
                n_is_read     = i_q_item.rd;
                n_byte_index  = '0;
                n_bit_count   = '0;
                n_retry_count = '0;
                n_shift       = '0;
                n_sda_drive   = 1'b1;
                n_sda_level   = 1'b0;
                n_phase       = PH_START1;
                n_scl         = 1'b1;
                n_tick_count  = at_least_one(r_scl_low);
            end
        end else if (r_tick_count > 8'd1) begin
            n_tick_count = r_tick_count - 1'b1;
        end else begin
            case (r_phase)
                PH_START1: begin
                    n_phase      = PH_START2;
                    n_scl        = 1'b0;
                    n_tick_count = at_least_one({1'b0, w_scl_low_eff[BYTE_W-1:1]});
                end
                PH_START2: begin
                    n_bit_count  = '0;
                    n_shift      = w_held_sel;
                    n_sda_drive  = 1'b1;
                    n_sda_level  = w_held_sel[BYTE_W-1];
                    n_phase      = PH_BIT_HIGH;
                    n_scl        = 1'b1;
                    n_tick_count = at_least_one(r_scl_high);
                end
                PH_BIT_HIGH: begin
                    n_phase      = PH_BIT_LOW;
                    n_scl        = 1'b0;
                    n_tick_count = at_least_one(r_scl_low);
                end
                PH_BIT_LOW: begin
                    n_bit_count = r_bit_count + 1'b1;
                    n_shift     = {r_shift[BYTE_W-2:0], 1'b0};
                    if (n_bit_count < BITS_PER_BYTE) begin
                        n_sda_drive  = 1'b1;
                        n_sda_level  = r_shift[BYTE_W-2];
                        n_phase      = PH_BIT_HIGH;
                        n_scl        = 1'b1;
                        n_tick_count = at_least_one(r_scl_high);
                    end else begin
                        n_sda_drive   = 1'b0;
                        n_retry_count = '0;
                        n_phase       = PH_ACK_WAIT;
                        n_scl         = 1'b0;
                        n_tick_count  = at_least_one(r_scl_high);
                    end
                end
                PH_ACK_WAIT, PH_ACK_POLL: begin
                    if (!i_q_item.sda_in) begin
                        n_phase      = PH_ACK_HIGH;
                        n_scl        = 1'b1;
                        n_tick_count = at_least_one(r_scl_high);
                    end else if (r_retry_count == r_retry_limit) begin
                        // ack timeout: end without stop
                        n_sda_drive  = 1'b1;
                        n_phase      = PH_IDLE;
                        n_tick_count = '0;
                        n_done       = 1'b1;
                    end else begin
                        n_retry_count = r_retry_count + 1'b1;
                        n_phase       = PH_ACK_POLL;
                        n_tick_count  = at_least_one(r_retry_delay);
                    end
                end
                PH_ACK_HIGH: begin
                    n_phase      = PH_ACK_LOW;
                    n_scl        = 1'b0;
                    n_tick_count = at_least_one(r_scl_low);
                end
                PH_ACK_LOW: begin
                    n_sda_drive  = 1'b1;
                    n_sda_level  = 1'b0;
                    n_byte_index = r_byte_index + 1'b1;
                    if (r_is_read && (n_byte_index == READ_DATA_IDX)) begin
                        n_sda_drive  = 1'b0;
                        n_bit_count  = '0;
                        n_shift      = '0;
                        n_phase      = PH_RD_HIGH;
                        n_scl        = 1'b1;
                        n_tick_count = at_least_one(r_scl_high);
                    end else if (n_byte_index == LAST_BYTE_IDX) begin
                        n_phase      = PH_STOP1;
                        n_scl        = 1'b1;
                        n_tick_count = at_least_one(r_stop_setup);
                    end else begin
                        n_bit_count  = '0;
                        n_shift      = w_held_sel;
                        n_sda_level  = w_held_sel[BYTE_W-1];
                        n_phase      = PH_BIT_HIGH;
                        n_scl        = 1'b1;
                        n_tick_count = at_least_one(r_scl_high);
                    end
                end
                PH_RD_HIGH: begin
                    n_shift      = {r_shift[BYTE_W-2:0], i_q_item.sda_in};
                    n_bit_count  = r_bit_count + 1'b1;
                    n_phase      = PH_RD_LOW;
                    n_scl        = 1'b0;
                    n_tick_count = at_least_one(r_scl_low);
                end
                PH_RD_LOW: begin
                    if (r_bit_count < BITS_PER_BYTE) begin
                        n_phase      = PH_RD_HIGH;
                        n_scl        = 1'b1;
                        n_tick_count = at_least_one(r_scl_high);
                    end else begin
                        n_sda_drive  = 1'b1;
                        n_sda_level  = 1'b0;
                        n_phase      = PH_STOP1;
                        n_scl        = 1'b1;
                        n_tick_count = at_least_one(r_stop_setup);
                    end
                end
                PH_STOP1: begin
                    n_sda_level  = 1'b1;
                    n_phase      = PH_STOP2;
                    n_scl        = 1'b1;
                    n_tick_count = at_least_one(r_bus_free);
                end
                PH_STOP2: begin
                    if (r_is_read) begin
                        n_read = r_shift;
                    end
                    n_phase      = PH_IDLE;
                    n_tick_count = '0;
                    n_done       = 1'b1;
                    n_success    = 1'b1;
                end
                default: begin
                    n_phase      = PH_IDLE;
                    n_tick_count = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scl_low     <= RST_SCL_LOW;
            r_scl_high    <= RST_SCL_HIGH;
            r_stop_setup  <= RST_STOP_SETUP;
            r_bus_free    <= RST_BUS_FREE;
            r_retry_limit <= RST_RETRY_LIMIT;
            r_retry_delay <= RST_RETRY_DELAY;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SCL_LOW:     r_scl_low     <= i_cfg_wdata;
                CFG_SCL_HIGH:    r_scl_high    <= i_cfg_wdata;
                CFG_STOP_SETUP:  r_stop_setup  <= i_cfg_wdata;
                CFG_BUS_FREE:    r_bus_free    <= i_cfg_wdata;
                CFG_RETRY_LIMIT: r_retry_limit <= i_cfg_wdata;
                CFG_RETRY_DELAY: r_retry_delay <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_byte_index  <= '0;
            r_bit_count   <= '0;
            r_tick_count  <= '0;
            r_retry_count <= '0;
            r_shift       <= '0;
            r_is_read     <= 1'b0;
            r_scl         <= 1'b1;
            r_sda_drive   <= 1'b1;
            r_sda_level   <= 1'b1;
            r_read        <= '0;
            r_done        <= 1'b0;
            r_success     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_phase       <= n_phase;
                r_byte_index  <= n_byte_index;
                r_bit_count   <= n_bit_count;
                r_tick_count  <= n_tick_count;
                r_retry_count <= n_retry_count;
                r_shift       <= n_shift;
                r_is_read     <= n_is_read;
                r_scl         <= n_scl;
                r_sda_drive   <= n_sda_drive;
                r_sda_level   <= n_sda_level;
                r_read        <= n_read;
                r_done        <= n_done;
                r_success     <= n_success;
                r_out_valid   <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && (r_phase == PH_IDLE) && i_q_item.start) begin
            r_held[0] <= i_q_item.dev_addr;
            r_held[1] <= i_q_item.reg_addr;
            r_held[2] <= i_q_item.write_data;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_scl_level = r_scl;
    assign o_sda_drive = r_sda_drive;
    assign o_sda_level = r_sda_level;
    assign o_busy_res  = (r_phase != PH_IDLE);
    assign o_done_res  = r_done;
    assign o_success   = r_success;
    assign o_read_data = r_read;

endmodule

### rtl/i2c_register_access_master_core.sv
// tick-driven i2c master for single register writes and reads
// input channel: one item per bus tick, carrying the sampled sda level and,
// while idle, a command (write or read) with device, register and data bytes;
// a command while busy, or an unknown code, counts as a plain tick
// output channel: one item per input item with the pin levels after that
// tick, busy, a one-tick done pulse, success and the last byte read
// config port: plain write of six 8-bit timing and retry registers; these are
// to be written only while no items are outstanding, not enforced by the block
// throughput: one item per cycle while the output is not stalled; the
// sequencer evaluates a whole tick combinationally and a small input queue
// absorbs output stalls; a taken item passes through the input queue and then
// the output register, and waits longer while other items wait in the queue
// reset: queue empty, bus idle with scl high and sda driven high, timing
// registers at their defaults, read byte zero
// a stalled result holds its values; input stall rises once the queue fills
module i2c_register_access_master_core #(
    parameter int unsigned QueueDepth = i2cram_pkg::QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [i2cram_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [7:0]                        i_cfg_wdata,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [1:0]                        i_command,
    input  logic [7:0]                        i_dev_addr,
    input  logic [7:0]                        i_reg_addr,
    input  logic [7:0]                        i_write_data,
    input  logic                              i_sda_in,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_scl_level,
    output logic                              o_sda_drive,
    output logic                              o_sda_level,
    output logic                              o_busy_res,
    output logic                              o_done_res,
    output logic                              o_success,
    output logic [7:0]                        o_read_data
);
    import i2cram_pkg::*;

    logic   w_q_valid;
    t_item  w_q_item;
    logic   w_q_pop;

    i2cram_front #(
        .QueueDepth (QueueDepth)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_command    (i_command),
        .i_dev_addr   (i_dev_addr),
        .i_reg_addr   (i_reg_addr),
        .i_write_data (i_write_data),
        .i_sda_in     (i_sda_in),
        .o_q_valid    (w_q_valid),
        .o_q_item     (w_q_item),
        .i_q_pop      (w_q_pop)
    );

    i2cram_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_item),
        .o_q_pop     (w_q_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_scl_level (o_scl_level),
        .o_sda_drive (o_sda_drive),
        .o_sda_level (o_sda_level),
        .o_busy_res  (o_busy_res),
        .o_done_res  (o_done_res),
        .o_success   (o_success),
        .o_read_data (o_read_data)
    );

    a_done_not_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done_res |-> !o_busy_res)
        else $error("done raised while still busy");

    a_success_with_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_success |-> o_done_res)
        else $error("success without done");

    a_pop_needs_item : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid)
        else $error("queue popped while empty");

    a_pop_gives_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |=> o_valid)
        else $error("popped item produced no result");

endmodule
